// File: hw/rtl/pat_pkg.sv
package pat_pkg;

  // Default table depth.
  localparam int CAPACITY_DEF = 64;

  // Field widths fixed by the item formats.
  localparam int DT_W   = 17;
  localparam int SLOT_W = 6;
  localparam int LIVE_W = 7;

  // Operation codes of an input item.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic                op;
    logic [DT_W-1:0]     dt;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic signed [31:0]  pos_z;
    logic signed [31:0]  vel_x;
    logic signed [31:0]  vel_y;
    logic signed [31:0]  vel_z;
    logic [31:0]         lifetime;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic signed [31:0]  out_x;
    logic signed [31:0]  out_y;
    logic signed [31:0]  out_z;
    logic                removed;
    logic                rejected;
    logic [LIVE_W-1:0]   live_count;
    logic                last;
  } out_item_t;

  // One table entry as it sits in the particle RAM.
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [31:0] age;
    logic [31:0] lifetime;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;
    logic tick_start;
    logic rd_first;
    logic eval;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic occ_zero;
    logic out_free;
    logic tick_last;
  } sts_t;

endpackage

// File: hw/rtl/pat_ram.sv
module pat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one read port with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/pat_ctrl.sv
module pat_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_ready,
  input  pat_pkg::sts_t sts,
  output pat_pkg::cmd_t cmd
);

  pat_pkg::state_t state_r;
  pat_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pat_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      pat_pkg::ST_IDLE: begin
        // An item is taken only when its first result can be stored.
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (in_op == pat_pkg::OP_INSERT) begin
            cmd.insert = 1'b1;
          end else begin
            cmd.tick_start = 1'b1;
            if (!sts.occ_zero) begin
              state_nxt = pat_pkg::ST_READ;
            end
          end
        end
      end
      pat_pkg::ST_READ: begin
        cmd.rd_first = 1'b1;
        state_nxt    = pat_pkg::ST_EVAL;
      end
      pat_pkg::ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = pat_pkg::ST_FIN;
      end
      pat_pkg::ST_FIN: begin
        // Finish the entry once the output register is free.
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = sts.tick_last ? pat_pkg::ST_IDLE : pat_pkg::ST_EVAL;
        end
      end
      default: begin
        state_nxt = pat_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/pat_datapath.sv
module pat_datapath #(
  parameter int CAPACITY = pat_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pat_pkg::cmd_t       cmd,
  output pat_pkg::sts_t       sts,
  input  pat_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output pat_pkg::out_item_t  out_item
);

  localparam int IdxW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int SlotW = pat_pkg::SLOT_W;
  localparam int LiveW = pat_pkg::LIVE_W;
  localparam int DtW   = pat_pkg::DT_W;
  localparam int EntW  = $bits(pat_pkg::entry_t);
  localparam logic signed [34:0] SumMax = 35'sd2147483647;
  localparam logic signed [34:0] SumMin = -35'sd2147483648;

  // Position plus the shifted displacement, saturated to 32 bits.
  function automatic logic [31:0] sat_add(logic [31:0] pos, logic signed [49:0] prod);
    logic signed [33:0] d;
    logic signed [34:0] s;
    d = 34'(prod >>> 16);
    s = 35'($signed(pos)) + 35'(d);
    if (s > SumMax) begin
      sat_add = 32'h7FFF_FFFF;
    end else if (s < SumMin) begin
      sat_add = 32'h8000_0000;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  logic [CntW-1:0]        occ_r, occ_nxt;
  logic [CntW-1:0]        idx_r, idx_nxt;
  logic [DtW-1:0]         dt_r, dt_nxt;
  logic [31:0]            age_r, age_nxt;
  logic                   expired_r, expired_nxt;
  logic signed [49:0]     prod_x_r, prod_x_nxt;
  logic signed [49:0]     prod_y_r, prod_y_nxt;
  logic signed [49:0]     prod_z_r, prod_z_nxt;
  logic                   out_valid_r, out_valid_nxt;
  pat_pkg::out_item_t     out_item_r, out_item_nxt;

  pat_pkg::entry_t        cur;
  pat_pkg::entry_t        wr_entry;
  logic [EntW-1:0]        rd_data;
  logic                   ram_we;
  logic [IdxW-1:0]        ram_waddr;
  logic                   ram_re;
  logic [IdxW-1:0]        ram_raddr;

  logic                   full;
  logic                   out_free;
  logic [CntW-1:0]        occ_dec;
  logic [CntW-1:0]        idx_inc;
  logic                   tick_last;
  logic [IdxW-1:0]        src_nxt;
  logic [32:0]            age_sum;
  logic [31:0]            age_sat;
  logic signed [17:0]     dt_s;
  logic [31:0]            new_x, new_y, new_z;

  assign cur = pat_pkg::entry_t'(rd_data);

  // Table status.
  assign full     = (occ_r == CntW'(CAPACITY));
  assign out_free = !out_valid_r || out_ready;
  assign occ_dec  = occ_r - 1'b1;
  assign idx_inc  = idx_r + 1'b1;

  // An expired entry pulls in the last one; a live one moves the walk on.
  assign tick_last = expired_r ? (occ_dec == idx_r) : (idx_inc == occ_r);
  assign src_nxt   = expired_r ? occ_dec[IdxW-1:0] : idx_inc[IdxW-1:0];

  assign sts.occ_zero  = (occ_r == '0);
  assign sts.out_free  = out_free;
  assign sts.tick_last = tick_last;

  // Age update and velocity products for the entry just read.
  assign age_sum = {1'b0, cur.age} + 33'(dt_r);
  assign age_sat = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
  assign dt_s    = $signed({1'b0, dt_r});

  // New positions from the registered products.
  assign new_x = sat_add(cur.pos_x, prod_x_r);
  assign new_y = sat_add(cur.pos_y, prod_y_r);
  assign new_z = sat_add(cur.pos_z, prod_z_r);

  // RAM port control.
  always_comb begin
    wr_entry  = cur;
    ram_we    = 1'b0;
    ram_waddr = idx_r[IdxW-1:0];
    if (cmd.insert) begin
      ram_we            = !full;
      ram_waddr         = occ_r[IdxW-1:0];
      wr_entry.pos_x    = in_item.pos_x;
      wr_entry.pos_y    = in_item.pos_y;
      wr_entry.pos_z    = in_item.pos_z;
      wr_entry.vel_x    = in_item.vel_x;
      wr_entry.vel_y    = in_item.vel_y;
      wr_entry.vel_z    = in_item.vel_z;
      wr_entry.age      = '0;
      wr_entry.lifetime = in_item.lifetime;
    end else begin
      ram_we         = cmd.fin && !expired_r;
      wr_entry.pos_x = new_x;
      wr_entry.pos_y = new_y;
      wr_entry.pos_z = new_z;
      wr_entry.age   = age_r;
    end
    ram_re    = cmd.rd_first || cmd.fin;
    ram_raddr = cmd.rd_first ? '0 : src_nxt;
  end

  // Next values of the datapath registers and the output register.
  always_comb begin
    occ_nxt       = occ_r;
    idx_nxt       = idx_r;
    dt_nxt        = dt_r;
    age_nxt       = age_r;
    expired_nxt   = expired_r;
    prod_x_nxt    = prod_x_r;
    prod_y_nxt    = prod_y_r;
    prod_z_nxt    = prod_z_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.insert) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.removed    = 1'b0;
      out_item_nxt.rejected   = full;
      out_item_nxt.last       = 1'b1;
      if (full) begin
        out_item_nxt.slot       = '0;
        out_item_nxt.out_x      = '0;
        out_item_nxt.out_y      = '0;
        out_item_nxt.out_z      = '0;
        out_item_nxt.live_count = LiveW'(occ_r);
      end else begin
        occ_nxt                 = occ_r + 1'b1;
        out_item_nxt.slot       = SlotW'(occ_r);
        out_item_nxt.out_x      = in_item.pos_x;
        out_item_nxt.out_y      = in_item.pos_y;
        out_item_nxt.out_z      = in_item.pos_z;
        out_item_nxt.live_count = LiveW'(occ_nxt);
      end
    end

    if (cmd.tick_start) begin
      dt_nxt  = in_item.dt;
      idx_nxt = '0;
    end

    if (cmd.eval) begin
      age_nxt     = age_sat;
      expired_nxt = (age_sat > cur.lifetime);
      prod_x_nxt  = $signed(cur.vel_x) * dt_s;
      prod_y_nxt  = $signed(cur.vel_y) * dt_s;
      prod_z_nxt  = $signed(cur.vel_z) * dt_s;
    end

    if (cmd.fin) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.slot     = SlotW'(idx_r);
      out_item_nxt.removed  = expired_r;
      out_item_nxt.rejected = 1'b0;
      out_item_nxt.last     = tick_last;
      if (expired_r) begin
        occ_nxt                 = occ_dec;
        out_item_nxt.out_x      = cur.pos_x;
        out_item_nxt.out_y      = cur.pos_y;
        out_item_nxt.out_z      = cur.pos_z;
        out_item_nxt.live_count = LiveW'(occ_dec);
      end else begin
        idx_nxt                 = idx_inc;
        out_item_nxt.out_x      = new_x;
        out_item_nxt.out_y      = new_y;
        out_item_nxt.out_z      = new_z;
        out_item_nxt.live_count = LiveW'(occ_r);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    dt_r       <= dt_nxt;
    age_r      <= age_nxt;
    expired_r  <= expired_nxt;
    prod_x_r   <= prod_x_nxt;
    prod_y_r   <= prod_y_nxt;
    prod_z_r   <= prod_z_nxt;
    out_item_r <= out_item_nxt;
  end

  pat_ram #(
    .WIDTH (EntW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: hw/rtl/particle_age_integrate_table_core.sv
// Particle table with age tracking and Euler position update.
//
// Input channel (in_valid/in_ready/in_item): an insert item appends a particle
// at the end of the table, or is rejected when the table is full; a tick item
// ages every live particle by dt, removes the expired ones (the last entry
// takes the freed slot) and advances the others by (vel*dt)>>16, saturating.
// Result channel (out_valid/out_ready/out_item): one result per insert, one
// per visited entry for a tick, with last set on the final one. A tick on an
// empty table gives no result.
// Timing: an insert shows its result in the cycle after it is accepted. A tick
// first starts the read of entry 0, then for each result evaluates the read data
// and multiplies, then adds, writes back and registers the result while issuing
// the next read; the pace is set by the registered read of the entry RAM and by
// each read address depending on whether the previous entry expired.
// Throughput: an insert can be taken every cycle while the receiver keeps up;
// after a tick the next item is taken once its last result is registered.
// Reset clears the particle count and the handshake state; the entry RAM is
// not cleared, since only entries below the count are ever used.
// When the receiver stalls, the finished result waits in the output register
// and the walk holds; a new item is taken only when that register is free.
module particle_age_integrate_table_core #(
  parameter int CAPACITY = pat_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pat_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output pat_pkg::out_item_t out_item
);

  pat_pkg::cmd_t cmd;
  pat_pkg::sts_t sts;

  pat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_item.op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pat_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// File: hw/rtl/pat_checker.sv
module pat_checker #(
  parameter int CAPACITY = pat_pkg::CAPACITY_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input pat_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input pat_pkg::out_item_t out_item
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // An accepted insert shows its result in the next cycle.
  a_insert_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_item.op == pat_pkg::OP_INSERT) |=> out_valid)
    else $error("insert result missing");

  // A rejection is a lone result and never a removal.
  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.rejected |-> out_item.last && !out_item.removed)
    else $error("malformed rejection");

  // A live particle reported sits below the count.
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.rejected && !out_item.removed |->
      (CAPACITY > 64) || (7'(out_item.slot) < out_item.live_count))
    else $error("slot beyond live count");

endmodule

bind particle_age_integrate_table_core pat_checker #(.CAPACITY(CAPACITY)) u_pat_checker (.*);

// File: sim/particle_age_integrate_table_core_test.sv
`timescale 1ns / 100ps

// Tracks the particle table as the block should hold it and keeps the results
// that each accepted item must produce, oldest first.
class particle_table_tracker;
  logic [31:0] pos_x [pat_pkg::CAPACITY_DEF];
  logic [31:0] pos_y [pat_pkg::CAPACITY_DEF];
  logic [31:0] pos_z [pat_pkg::CAPACITY_DEF];
  logic [31:0] vel_x [pat_pkg::CAPACITY_DEF];
  logic [31:0] vel_y [pat_pkg::CAPACITY_DEF];
  logic [31:0] vel_z [pat_pkg::CAPACITY_DEF];
  logic [31:0] age [pat_pkg::CAPACITY_DEF];
  logic [31:0] life [pat_pkg::CAPACITY_DEF];
  int unsigned live;
  pat_pkg::out_item_t expected_reports [$];
  int unsigned mismatches;

  function new();
    live = 0;
    mismatches = 0;
  endfunction

  // One Euler step on one axis: the product is exact, the shift floors and the
  // sum clamps to the signed 32-bit range.
  function logic [31:0] advance_axis(logic [31:0] pos, logic [31:0] vel,
                                     logic [pat_pkg::DT_W-1:0] dt);
    logic signed [63:0] prod;
    logic signed [63:0] sum;
    prod = $signed({{32{vel[31]}}, vel}) * $signed({47'd0, dt});
    sum = $signed({{32{pos[31]}}, pos}) + (prod >>> 16);
    if (sum > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (sum < -64'sh8000_0000) return 32'h8000_0000;
    return sum[31:0];
  endfunction

  // Applies an accepted item to the table and queues the results it causes.
  function void note_accepted(pat_pkg::in_item_t it);
    pat_pkg::out_item_t r;
    logic [32:0] aged;
    int unsigned i;
    int unsigned src;
    if (it.op == pat_pkg::OP_INSERT) begin
      r = '0;
      r.last = 1'b1;
      if (live >= pat_pkg::CAPACITY_DEF) begin
        r.rejected = 1'b1;
      end else begin
        pos_x[live] = it.pos_x;
        pos_y[live] = it.pos_y;
        pos_z[live] = it.pos_z;
        vel_x[live] = it.vel_x;
        vel_y[live] = it.vel_y;
        vel_z[live] = it.vel_z;
        life[live] = it.lifetime;
        age[live] = '0;
        r.slot = pat_pkg::SLOT_W'(live);
        r.out_x = it.pos_x;
        r.out_y = it.pos_y;
        r.out_z = it.pos_z;
        live++;
      end
      r.live_count = pat_pkg::LIVE_W'(live);
      expected_reports.push_back(r);
    end else begin
      i = 0;
      while (i < live) begin
        aged = {1'b0, age[i]} + 33'(it.dt);
        if (aged[32]) aged = 33'h0_FFFF_FFFF;
        age[i] = aged[31:0];
        r = '0;
        r.slot = pat_pkg::SLOT_W'(i);
        if (age[i] > life[i]) begin
          // Expired: report the old position, then pull the last entry in.
          r.out_x = pos_x[i];
          r.out_y = pos_y[i];
          r.out_z = pos_z[i];
          r.removed = 1'b1;
          live--;
          src = live;
          if (src != i) begin
            pos_x[i] = pos_x[src];
            pos_y[i] = pos_y[src];
            pos_z[i] = pos_z[src];
            vel_x[i] = vel_x[src];
            vel_y[i] = vel_y[src];
            vel_z[i] = vel_z[src];
            age[i] = age[src];
            life[i] = life[src];
          end
        end else begin
          pos_x[i] = advance_axis(pos_x[i], vel_x[i], it.dt);
          pos_y[i] = advance_axis(pos_y[i], vel_y[i], it.dt);
          pos_z[i] = advance_axis(pos_z[i], vel_z[i], it.dt);
          r.out_x = pos_x[i];
          r.out_y = pos_y[i];
          r.out_z = pos_z[i];
          i++;
        end
        r.live_count = pat_pkg::LIVE_W'(live);
        // The walk ends exactly when the index reaches the live count.
        r.last = (i >= live);
        expected_reports.push_back(r);
      end
    end
  endfunction

  // Prints one line per mismatch; printing stops after a hundred.
  task report_mismatch(string msg);
    if (mismatches < 100) $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Compares an accepted result with the oldest expected one.
  task check_report(pat_pkg::out_item_t got);
    pat_pkg::out_item_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("result for slot %0d with none expected", got.slot));
      return;
    end
    want = expected_reports.pop_front();
    if (got.slot !== want.slot)
      report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
    if (got.out_x !== want.out_x)
      report_mismatch($sformatf("slot %0d out_x %h, want %h", want.slot, got.out_x,
                                want.out_x));
    if (got.out_y !== want.out_y)
      report_mismatch($sformatf("slot %0d out_y %h, want %h", want.slot, got.out_y,
                                want.out_y));
    if (got.out_z !== want.out_z)
      report_mismatch($sformatf("slot %0d out_z %h, want %h", want.slot, got.out_z,
                                want.out_z));
    if (got.removed !== want.removed)
      report_mismatch($sformatf("slot %0d removed %b, want %b", want.slot, got.removed,
                                want.removed));
    if (got.rejected !== want.rejected)
      report_mismatch($sformatf("slot %0d rejected %b, want %b", want.slot,
                                got.rejected, want.rejected));
    if (got.live_count !== want.live_count)
      report_mismatch($sformatf("slot %0d live_count %0d, want %0d", want.slot,
                                got.live_count, want.live_count));
    if (got.last !== want.last)
      report_mismatch($sformatf("slot %0d last %b, want %b", want.slot, got.last,
                                want.last));
  endtask
endclass

module particle_age_integrate_table_core_test;

  localparam logic [pat_pkg::DT_W-1:0] DT_MAX = '1;
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;
  // Full-step ticks given to the first two long-lived particles.
  localparam int unsigned FULL_STEP_TICKS = 4;
  // A full table walk, with some margin.
  localparam int unsigned SETTLE_CYCLES = 2 * pat_pkg::CAPACITY_DEF + 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pat_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pat_pkg::out_item_t out_item;

  int unsigned sender_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  particle_table_tracker sb;

  particle_age_integrate_table_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Give up after far longer than the slowest legal run.
  initial begin
    #40_000_000;
    $display("** particle_age_integrate_table_core: FAILED **");
    $finish;
  end

  // The receiver stalls at random at the current rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Handshakes are sampled mid-cycle, where every signal is settled; an item
  // seen here is taken at the following rising edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_accepted(in_item);
      if (out_valid && out_ready) sb.check_report(out_item);
    end
  end

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(4))
      0: return S32_MAX;
      1: return S32_MIN;
      2: return 32'h0;
      3: return U32_MAX;
      default: return 32'h1;
    endcase
  endfunction

  // Mostly small signed values, with extremes and full-range values mixed in.
  function automatic logic [31:0] rand_coord(logic [31:0] span);
    logic [31:0] v;
    case ($urandom_range(9))
      0: v = pick_extreme();
      1, 2: v = $urandom();
      default: begin
        v = $urandom_range(0, span);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Lifetimes mostly last a few ticks so that the table keeps changing.
  function automatic logic [31:0] rand_life();
    case ($urandom_range(19))
      0, 1: return $urandom();
      2: return $urandom_range(1) ? U32_MAX : 32'h0;
      default: return $urandom_range(0, 32'h0006_0000);
    endcase
  endfunction

  function automatic logic [pat_pkg::DT_W-1:0] rand_dt();
    case ($urandom_range(9))
      0: return DT_MAX;
      1: return pat_pkg::DT_W'($urandom_range(1));
      default: return pat_pkg::DT_W'($urandom_range(0, DT_MAX));
    endcase
  endfunction

  function automatic pat_pkg::in_item_t make_insert(logic [31:0] px, logic [31:0] py,
                                                    logic [31:0] pz, logic [31:0] vx,
                                                    logic [31:0] vy, logic [31:0] vz,
                                                    logic [31:0] life);
    pat_pkg::in_item_t it;
    it.op = pat_pkg::OP_INSERT;
    it.dt = pat_pkg::DT_W'($urandom());
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    it.vel_x = vx;
    it.vel_y = vy;
    it.vel_z = vz;
    it.lifetime = life;
    return it;
  endfunction

  // Fields other than the step carry noise; the block must not use them.
  function automatic pat_pkg::in_item_t make_tick(logic [pat_pkg::DT_W-1:0] dt);
    pat_pkg::in_item_t it;
    it = make_insert($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom());
    it.op = pat_pkg::OP_TICK;
    it.dt = dt;
    return it;
  endfunction

  function automatic pat_pkg::in_item_t random_insert();
    return make_insert(rand_coord(32'h00FF_FFFF), rand_coord(32'h00FF_FFFF),
                       rand_coord(32'h00FF_FFFF), rand_coord(32'h0003_FFFF),
                       rand_coord(32'h0003_FFFF), rand_coord(32'h0003_FFFF),
                       rand_life());
  endfunction

  // Presents one item after a random gap and returns at the edge that takes it.
  task automatic send_item(input pat_pkg::in_item_t it);
    bit taken;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
  endtask

  // Holds the sender until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_reports.size() != 0);
  endtask

  task automatic run_directed();
    int unsigned k;
    // A tick on the empty table gives no result.
    send_item(make_tick(rand_dt()));
    // Two long-lived particles that survive a few full steps.
    send_item(make_insert(rand_coord(32'hFFFF), rand_coord(32'hFFFF),
                          rand_coord(32'hFFFF), rand_coord(32'hFFFF),
                          rand_coord(32'hFFFF), rand_coord(32'hFFFF),
                          32'hFFFF_FFFE));
    send_item(make_insert(rand_coord(32'hFFFF), rand_coord(32'hFFFF),
                          rand_coord(32'hFFFF), rand_coord(32'hFFFF),
                          rand_coord(32'hFFFF), rand_coord(32'hFFFF), U32_MAX));
    for (k = 0; k < FULL_STEP_TICKS; k++) send_item(make_tick(DT_MAX));
    // Extreme positions and velocities that clamp high and low.
    send_item(make_insert(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX,
                          S32_MAX));
    send_item(make_insert(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
                          32'h00FF_FFFF));
    // Zero lifetime, and a tiny negative velocity whose shift rounds down.
    send_item(make_insert(32'h0, 32'h0, 32'h0, U32_MAX, U32_MAX, U32_MAX, 32'h0));
    send_item(make_insert(U32_MAX, U32_MAX, U32_MAX, 32'h1, 32'h1, 32'h1,
                          32'h0001_0000));
    send_item(make_insert(32'h0, 32'h0, 32'h0, U32_MAX, 32'h1, U32_MAX, S32_MAX));
    // A zero step keeps even the zero-lifetime particle alive.
    send_item(make_tick('0));
    send_item(make_tick(pat_pkg::DT_W'(1)));
    send_item(make_tick(DT_MAX));
    // Mixed signs per axis.
    send_item(make_insert(S32_MAX, S32_MIN, 32'h0, S32_MIN, S32_MAX, 32'h0001_0000,
                          U32_MAX));
    // Two expiring entries at the end: the one moved in expires too, and the
    // last removal leaves no entry to move.
    send_item(make_insert(32'h1234_5678, 32'h0, U32_MAX, 32'h0, 32'h0, 32'h0, 32'h0));
    send_item(make_insert(32'h0, 32'h8765_4321, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0));
    send_item(make_tick(17'h1_0000));
    send_item(make_tick(rand_dt()));
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      // Now and then the sender waits for the table to report everything.
      if ($urandom_range(99) < 3) drain_results();
      if ($urandom_range(99) < 55) send_item(random_insert());
      else send_item(make_tick(rand_dt()));
    end
  endtask

  // Fills the table to capacity, then offers two inserts that must be refused.
  task automatic fill_table();
    while (sb.live < pat_pkg::CAPACITY_DEF) send_item(random_insert());
    send_item(random_insert());
    send_item(random_insert());
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slow receiver.
    sender_idle_pct = 22;
    sink_idle_pct = 82;
    run_directed();
    run_random(70);
    drain_results();

    // Slow sender, with the table driven to full.
    sender_idle_pct = 82;
    sink_idle_pct = 22;
    fill_table();
    run_random(40);
    drain_results();

    // Back to back on both sides.
    sender_idle_pct = 0;
    sink_idle_pct = 0;
    run_random(40);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
      $display("** particle_age_integrate_table_core: PASSED **");
    end else begin
      $display("** particle_age_integrate_table_core: FAILED **");
    end
    $finish;
  end

endmodule
